// ----- rtl/core/b58enc_pkg.sv -----
// Shared types, constants and the digit-to-character map for the base58 block encoder.
// No dependencies; used by b58enc_ctrl, b58enc_dp and base58_block_encoder.
package b58enc_pkg;

    localparam int          MAX_BYTES_DEF = 32;
    localparam int          CHAR_W        = 7;
    localparam int          CAP_W         = 6;
    localparam logic [6:0]  LIMIT_RESET   = 7'd64;
    localparam logic [6:0]  LIMIT_MIN     = 7'd2;
    localparam logic [6:0]  LIMIT_MAX     = 7'd64;
    localparam logic [6:0]  B58_BASE      = 7'd58;
    localparam logic [6:0]  CHAR_ONE      = 7'd49;    // '1', the zero digit
    localparam logic [6:0]  CHAR_NONE     = 7'd0;

    localparam logic [1:0]  STAT_OK       = 2'd0;
    localparam logic [1:0]  STAT_TRUNC    = 2'd1;
    localparam logic [1:0]  STAT_ZOVF     = 2'd2;

    typedef struct packed {
        logic take;         // input byte transfer
        logic clear;        // block finished, drop counts
        logic conv_init;    // set up the digit conversion
        logic pass_start;   // start one divide-by-58 pass
        logic pass_run;     // pass in progress
        logic pass_end;     // store the remainder as the next digit
        logic emit_init;    // set up the output sequence
        logic emit_load;    // load the next character into the output register
        logic err_load;     // load the leading-zero overflow result
    } t_cmd;

    typedef struct packed {
        logic zero_over;    // leading zeros reach the limit
        logic has_digits;   // number still nonzero
        logic pass_done;
        logic out_free;     // output register can take a result
        logic emit_ready;   // next character available
        logic emit_last;    // next character ends the string
    } t_sts;

    // digit 0..57 to alphabet character
    function automatic logic [6:0] b58_char(input logic [5:0] d);
        logic [6:0] c;
        case (d) inside
            [6'd0:6'd8]:   c = 7'(d) + 7'd49;
            [6'd9:6'd16]:  c = 7'(d) + 7'd56;
            [6'd17:6'd21]: c = 7'(d) + 7'd57;
            [6'd22:6'd32]: c = 7'(d) + 7'd58;
            [6'd33:6'd43]: c = 7'(d) + 7'd64;
            [6'd44:6'd57]: c = 7'(d) + 7'd65;
            default:       c = CHAR_ONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/base58_block_encoder.sv -----
// Base58 block encoder: bytes in, most significant first; alphabet characters out.
// Intake takes one byte per cycle. After the last byte each divide-by-58 pass walks
// the stored bytes from the first nonzero one onward, one byte per cycle (up to 44
// passes for 32 bytes); leading '1's leave at one per cycle while the output is ready,
// each digit waits for its registered digit-store read. One block is in work at a time.
// Reset (synchronous, active low) clears all control state and sets the limit to 64.
module base58_block_encoder #(
    parameter int MAX_BYTES = b58enc_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic        m_axis_tlast,   // final_char
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // out_limit
);

    b58enc_pkg::t_cmd cmd;
    b58enc_pkg::t_sts sts;
    logic [6:0]       out_char;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {1'b0, out_char};

    b58enc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .o_in_ready    (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    b58enc_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_byte       (s_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_char   (out_char),
        .o_out_final  (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

endmodule

// ----- rtl/core/b58enc_ctrl.sv -----
// Sequencer of the base58 block encoder: byte intake, division passes, output.
// Depends on b58enc_pkg; drives b58enc_dp through t_cmd and reads t_sts.
module b58enc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tlast,
    output logic               o_in_ready,
    input  b58enc_pkg::t_sts   i_sts,
    output b58enc_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_NEXT  = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IN);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IN: begin
                o_cmd.take = s_axis_tvalid;
                if (s_axis_tvalid && s_axis_tlast) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.zero_over) begin
                    if (i_sts.out_free) begin
                        o_cmd.err_load = 1'b1;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_IN;
                    end
                end else begin
                    o_cmd.conv_init = 1'b1;
                    n_state         = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.has_digits) begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_PASS;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_PASS: begin
                o_cmd.pass_run = 1'b1;
                if (i_sts.pass_done) begin
                    o_cmd.pass_end = 1'b1;
                    n_state        = S_NEXT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.emit_ready) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IN;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/b58enc_dp.sv -----
// Datapath of the base58 block encoder: byte store, byte-serial divide by 58,
// digit store, limit register and output register. Depends on b58enc_pkg.
module b58enc_dp #(
    parameter int MAX_BYTES = b58enc_pkg::MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b58enc_pkg::t_cmd   i_cmd,
    output b58enc_pkg::t_sts   o_sts,
    input  logic [7:0]         i_byte,
    input  logic               i_cfg_valid,
    input  logic [6:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_out_char,
    output logic               o_out_final,
    output logic [1:0]         o_out_status
);

    // base-58 digits of a MAX_BYTES number: ceil(8 * MAX_BYTES * log58(2))
    localparam int DIGIT_DEPTH = (MAX_BYTES * 1366) / 1000 + 1;
    localparam int CW   = $clog2(MAX_BYTES + 1);
    localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int DW   = $clog2(DIGIT_DEPTH + 1);
    localparam int DAW  = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
    localparam int TW   = ((CW > DW) ? CW : DW) + 1;
    localparam int CMPW = (TW > b58enc_pkg::CAP_W) ? TW : b58enc_pkg::CAP_W;

    // one long-division step: {rem, byte} / 58, one quotient bit per stage
    function automatic logic [13:0] div58_step(input logic [5:0] rem, input logic [7:0] din);
        logic [6:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[5:0], din[i]};
            if (r >= b58enc_pkg::B58_BASE) begin
                r    = r - b58enc_pkg::B58_BASE;
                q[i] = 1'b1;
            end
        end
        return {q, r[5:0]};
    endfunction

    logic [6:0]    r_limit;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_zero;
    logic          r_seen;

    logic [7:0]    r_num [MAX_BYTES];
    logic [7:0]    r_nq;
    logic [5:0]    r_dig [DIGIT_DEPTH];
    logic [5:0]    r_dq;

    logic [CW-1:0] r_start;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_paddr;
    logic          r_pv;
    logic [5:0]    r_rem;
    logic          r_found;
    logic [CW-1:0] r_nstart;
    logic [DW-1:0] r_nd;

    logic [CMPW-1:0]                r_total;
    logic [b58enc_pkg::CAP_W-1:0]   r_emit;
    logic                           r_trunc;
    logic                           r_empty;
    logic [b58enc_pkg::CAP_W-1:0]   r_k;
    logic                           r_rd_ok;

    logic          r_ovalid;
    logic [6:0]    r_char;
    logic          r_final;
    logic [1:0]    r_stat;

    logic [6:0]                     lim;
    logic [b58enc_pkg::CAP_W-1:0]   cap;
    logic                           store_en;
    logic                           rd_en;
    logic [13:0]                    step;
    logic [CMPW-1:0]                total_now;
    logic [CMPW-1:0]                daddr_full;
    logic                           k_in_zeros;
    logic                           out_free;

    always_comb begin
        if (r_limit < b58enc_pkg::LIMIT_MIN) begin
            lim = b58enc_pkg::LIMIT_MIN;
        end else if (r_limit > b58enc_pkg::LIMIT_MAX) begin
            lim = b58enc_pkg::LIMIT_MAX;
        end else begin
            lim = r_limit;
        end
    end
    assign cap = b58enc_pkg::CAP_W'(lim - 7'd1);

    assign store_en   = i_cmd.take && (r_count < CW'(MAX_BYTES));
    assign rd_en      = i_cmd.pass_run && (r_idx < r_count);
    assign step       = div58_step(r_rem, r_nq);
    assign total_now  = CMPW'(r_zero) + CMPW'(r_nd);
    assign daddr_full = r_total - CMPW'(1) - CMPW'(r_k);
    assign k_in_zeros = CMPW'(r_k) < CMPW'(r_zero);
    assign out_free   = !r_ovalid || i_out_ready;

    always_comb begin
        o_sts.zero_over  = CMPW'(r_zero) > CMPW'(cap);
        o_sts.has_digits = r_start < r_count;
        o_sts.pass_done  = (r_idx >= r_count) && !r_pv;
        o_sts.out_free   = out_free;
        o_sts.emit_ready = r_empty || k_in_zeros || r_rd_ok;
        o_sts.emit_last  = r_empty || ((r_k + 1'b1) == r_emit);
    end

    // byte store: intake writes, division passes overwrite with quotients
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_num[r_count[AW-1:0]] <= i_byte;
        end else if (r_pv) begin
            r_num[r_paddr[AW-1:0]] <= step[13:6];
        end
        if (rd_en) begin
            r_nq <= r_num[r_idx[AW-1:0]];
        end
    end

    // digit store, least significant digit at address 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_end && (r_nd < DW'(DIGIT_DEPTH))) begin
            r_dig[r_nd[DAW-1:0]] <= r_rem;
        end
        r_dq <= r_dig[daddr_full[DAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= b58enc_pkg::LIMIT_RESET;
            r_count <= '0;
            r_zero  <= '0;
            r_seen  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_zero  <= '0;
                r_seen  <= 1'b0;
            end else if (store_en) begin
                r_count <= r_count + 1'b1;
                if (!r_seen) begin
                    if (i_byte == 8'd0) begin
                        r_zero <= r_zero + 1'b1;
                    end else begin
                        r_seen <= 1'b1;
                    end
                end
            end
        end
    end

    // division passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_start <= '0;
            r_nd    <= '0;
        end else begin
            if (i_cmd.conv_init) begin
                r_start <= r_zero;
                r_nd    <= '0;
            end
            if (i_cmd.pass_start) begin
                r_idx   <= r_start;
                r_rem   <= '0;
                r_pv    <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.pass_run) begin
                r_pv    <= rd_en;
                r_paddr <= r_idx;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pv) begin
                    r_rem <= step[5:0];
                    // first nonzero quotient byte is where the next pass starts
                    if ((step[13:6] != 8'd0) && !r_found) begin
                        r_found  <= 1'b1;
                        r_nstart <= r_paddr;
                    end
                end
            end
            if (i_cmd.pass_end) begin
                r_start <= r_found ? r_nstart : r_count;
                r_nd    <= r_nd + 1'b1;
            end
        end
    end

    // output sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
            r_emit   <= '0;
            r_empty  <= 1'b0;
            r_trunc  <= 1'b0;
            r_total  <= '0;
        end else begin
            if (i_cmd.emit_init) begin
                r_total <= total_now;
                r_trunc <= total_now > CMPW'(cap);
                r_emit  <= (total_now > CMPW'(cap)) ? cap : b58enc_pkg::CAP_W'(total_now);
                r_empty <= total_now == '0;
                r_k     <= '0;
                r_rd_ok <= 1'b0;
            end else if (i_cmd.emit_load) begin
                r_k     <= r_k + 1'b1;
                r_rd_ok <= 1'b0;
            end else begin
                r_rd_ok <= 1'b1;
            end

            if (i_cmd.err_load) begin
                r_ovalid <= 1'b1;
                r_char   <= b58enc_pkg::CHAR_NONE;
                r_final  <= 1'b1;
                r_stat   <= b58enc_pkg::STAT_ZOVF;
            end else if (i_cmd.emit_load) begin
                r_ovalid <= 1'b1;
                r_final  <= o_sts.emit_last;
                if (r_empty) begin
                    r_char <= b58enc_pkg::CHAR_NONE;
                    r_stat <= b58enc_pkg::STAT_OK;
                end else begin
                    r_char <= k_in_zeros ? b58enc_pkg::CHAR_ONE : b58enc_pkg::b58_char(r_dq);
                    r_stat <= r_trunc ? b58enc_pkg::STAT_TRUNC : b58enc_pkg::STAT_OK;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_char   = r_char;
    assign o_out_final  = r_final;
    assign o_out_status = r_stat;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.err_load) |-> out_free)
        else $error("result loaded while output register busy");

    a_pass_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_paddr < r_count))
        else $error("division pass beyond stored bytes");

    a_digit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_end |-> (r_nd < DW'(DIGIT_DEPTH)))
        else $error("digit store overflow");

    a_digit_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load && !r_empty && !k_in_zeros) |-> $past(daddr_full) == daddr_full)
        else $error("digit emitted before its read settled");

endmodule
